### sv/kvt_pkg.sv
// Shared types and constants for the key-value table with valid marks.
// Holds the request/response structs, operation codes and controller links.
// Used by kvt_ctrl, kvt_dp and the top module; depends on nothing.
package kvt_pkg;

  // Table geometry
  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = $clog2(ENTRIES + 1);

  // Fixed field widths of the response
  localparam int INDEX_BITS = 4;
  localparam int COUNT_BITS = 5;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [INDEX_BITS-1:0] index_field_t;
  typedef logic [COUNT_BITS-1:0] count_field_t;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_SET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    op_t          operation;
    logic [31:0]  key_in;
    logic [31:0]  value_in;
    logic         value_in_valid;
  } req_t;

  typedef struct packed {
    logic         hit;
    logic         changed;
    logic [31:0]  value_out;
    logic         value_out_valid;
    index_field_t entry_index;
    count_field_t entry_count;
    logic         table_full;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic search;
    logic fetch;
    logic apply;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic found;
    logic slot_is_last;
    logic search_done;
    logic out_free;
  } status_t;

endpackage

### sv/kvt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the key and value stores.
module kvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/kvt_ctrl.sv
// Controller for the key-value table: sequences search, fetch, update, reply.
// Depends on kvt_pkg for the command and status structs.
module kvt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  kvt_pkg::op_t     in_op,
  output logic             in_ready,
  input  kvt_pkg::status_t st,
  output kvt_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_FETCH,
    S_APPLY,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   need_fetch;

  // Lookup hit needs the value; remove of a non-last slot needs the last entry
  assign need_fetch = st.found &&
                      ((st.op == kvt_pkg::OP_LOOKUP) ||
                       ((st.op == kvt_pkg::OP_REMOVE) && !st.slot_is_last));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_op == kvt_pkg::OP_CLEAR) ? S_APPLY : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (st.search_done) begin
          state_nxt = need_fetch ? S_FETCH : S_APPLY;
        end
      end
      S_FETCH: state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_DONE;
      S_DONE: begin
        if (st.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode commands
  assign in_ready   = (state_r == S_IDLE);
  assign cmd.load   = (state_r == S_IDLE) && in_valid;
  assign cmd.search = (state_r == S_SEARCH);
  assign cmd.fetch  = (state_r == S_FETCH);
  assign cmd.apply  = (state_r == S_APPLY);
  assign cmd.emit   = (state_r == S_DONE) && st.out_free;

endmodule

### sv/kvt_dp.sv
// Datapath for the key-value table: key and value RAMs, mark flops, count,
// linear search pipeline and the response register. Depends on kvt_pkg, kvt_ram.
module kvt_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  kvt_pkg::req_t    in_req,
  input  kvt_pkg::cmd_t    cmd,
  output kvt_pkg::status_t st,
  output logic             out_valid,
  input  logic             out_ready,
  output kvt_pkg::rsp_t    out_rsp
);

  kvt_pkg::req_t                  req_r, req_nxt;
  kvt_pkg::cnt_t                  scan_r, scan_nxt;
  logic                           pend_r, pend_nxt;
  kvt_pkg::idx_t                  pend_idx_r, pend_idx_nxt;
  logic                           found_r, found_nxt;
  kvt_pkg::idx_t                  slot_r, slot_nxt;
  logic                           full_r, full_nxt;
  logic                           ins_r, ins_nxt;
  kvt_pkg::cnt_t                  count_r, count_nxt;
  logic [kvt_pkg::ENTRIES-1:0]    marks_r, marks_nxt;
  kvt_pkg::value_t                vout_r, vout_nxt;
  logic                           vvld_r, vvld_nxt;
  logic                           out_valid_r, out_valid_nxt;
  kvt_pkg::rsp_t                  out_rsp_r, out_rsp_nxt;

  kvt_pkg::key_t   key_rdata, key_wdata;
  kvt_pkg::value_t val_rdata, val_wdata, set_value;
  kvt_pkg::idx_t   key_raddr, val_raddr, waddr;
  logic            key_we, val_we;
  kvt_pkg::cnt_t   last_full;
  kvt_pkg::idx_t   last_idx;
  kvt_pkg::idx_t   count_idx;
  logic            match;
  logic            can_issue;
  logic            is_full;
  logic            do_insert;
  logic            do_move;
  kvt_pkg::rsp_t   rsp;

  assign last_full = count_r - kvt_pkg::cnt_t'(1);
  assign last_idx  = last_full[kvt_pkg::IDX_W-1:0];
  assign count_idx = count_r[kvt_pkg::IDX_W-1:0];
  assign is_full   = (count_r == kvt_pkg::cnt_t'(kvt_pkg::ENTRIES));
  assign set_value = req_r.value_in_valid ? kvt_pkg::value_t'(req_r.value_in) : '0;

  // Search: compare the key read last cycle, issue the next slot
  assign match     = pend_r && (key_rdata == kvt_pkg::key_t'(req_r.key_in));
  assign can_issue = !found_r && !match && (scan_r < count_r);

  // RAM read addresses
  assign key_raddr = cmd.fetch ? last_idx : scan_r[kvt_pkg::IDX_W-1:0];
  assign val_raddr = (req_r.operation == kvt_pkg::OP_LOOKUP) ? slot_r : last_idx;

  // RAM writes during the update step
  assign do_insert = cmd.apply && (req_r.operation == kvt_pkg::OP_SET) &&
                     !found_r && !is_full;
  assign do_move   = cmd.apply && (req_r.operation == kvt_pkg::OP_REMOVE) &&
                     found_r && (slot_r != last_idx);
  assign key_we    = do_insert || do_move;
  assign val_we    = do_insert || do_move ||
                     (cmd.apply && (req_r.operation == kvt_pkg::OP_SET) && found_r);
  assign waddr     = do_insert ? count_idx : slot_r;
  assign key_wdata = do_move ? key_rdata : kvt_pkg::key_t'(req_r.key_in);
  assign val_wdata = do_move ? val_rdata : set_value;

  kvt_ram #(
    .WIDTH (kvt_pkg::KEY_BITS),
    .DEPTH (kvt_pkg::ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  kvt_ram #(
    .WIDTH (kvt_pkg::VALUE_BITS),
    .DEPTH (kvt_pkg::ENTRIES)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  // Assemble the response from the finished request
  always_comb begin
    rsp                 = '0;
    rsp.hit             = found_r;
    rsp.changed         = ins_r || ((req_r.operation == kvt_pkg::OP_REMOVE) && found_r);
    rsp.value_out       = 32'(vout_r);
    rsp.value_out_valid = vvld_r;
    rsp.entry_index     = kvt_pkg::index_field_t'(slot_r);
    rsp.entry_count     = kvt_pkg::count_field_t'(count_r);
    rsp.table_full      = full_r;
  end

  // Next-state logic for all datapath registers
  always_comb begin
    req_nxt       = req_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    full_nxt      = full_r;
    ins_nxt       = ins_r;
    count_nxt     = count_r;
    marks_nxt     = marks_r;
    vout_nxt      = vout_r;
    vvld_nxt      = vvld_r;
    out_valid_nxt = out_valid_r;
    out_rsp_nxt   = out_rsp_r;

    // Latch a new request and clear per-request flags
    if (cmd.load) begin
      req_nxt   = in_req;
      scan_nxt  = '0;
      pend_nxt  = 1'b0;
      found_nxt = 1'b0;
      slot_nxt  = '0;
      full_nxt  = 1'b0;
      ins_nxt   = 1'b0;
      vout_nxt  = '0;
      vvld_nxt  = 1'b0;
    end

    // Advance the linear search by one slot
    if (cmd.search) begin
      if (match) begin
        found_nxt = 1'b1;
        slot_nxt  = pend_idx_r;
      end
      pend_nxt = can_issue;
      if (can_issue) begin
        pend_idx_nxt = scan_r[kvt_pkg::IDX_W-1:0];
        scan_nxt     = scan_r + kvt_pkg::cnt_t'(1);
      end
    end

    // Update marks and count, and capture the per-request result
    if (cmd.apply) begin
      case (req_r.operation)
        kvt_pkg::OP_LOOKUP: begin
          if (found_r) begin
            vout_nxt = val_rdata;
            vvld_nxt = marks_r[slot_r];
          end
        end
        kvt_pkg::OP_SET: begin
          if (found_r) begin
            marks_nxt[slot_r] = req_r.value_in_valid;
          end else if (is_full) begin
            full_nxt = 1'b1;
          end else begin
            marks_nxt[count_idx] = req_r.value_in_valid;
            count_nxt            = count_r + kvt_pkg::cnt_t'(1);
            ins_nxt              = 1'b1;
            slot_nxt             = count_idx;
          end
        end
        kvt_pkg::OP_REMOVE: begin
          if (found_r) begin
            marks_nxt[slot_r]   = marks_r[last_idx];
            marks_nxt[last_idx] = 1'b0;
            count_nxt           = last_full;
          end
        end
        kvt_pkg::OP_CLEAR: begin
          marks_nxt = '0;
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end

    // Response register: load on emit, drop once taken
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_rsp_nxt   = rsp;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      full_r      <= 1'b0;
      ins_r       <= 1'b0;
      count_r     <= '0;
      marks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      full_r      <= full_nxt;
      ins_r       <= ins_nxt;
      count_r     <= count_nxt;
      marks_r     <= marks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    scan_r     <= scan_nxt;
    pend_idx_r <= pend_idx_nxt;
    slot_r     <= slot_nxt;
    vout_r     <= vout_nxt;
    vvld_r     <= vvld_nxt;
    out_rsp_r  <= out_rsp_nxt;
  end

  // Status back to the controller
  assign st.op           = req_r.operation;
  assign st.found        = found_r;
  assign st.slot_is_last = (slot_r == last_idx);
  assign st.search_done  = found_r || (!pend_r && !can_issue);
  assign st.out_free     = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

### sv/key_value_table_with_valid_marks.sv
// Unordered key-value table of kvt_pkg::ENTRIES slots, each holding a key, a
// value and a valid mark. A request (lookup, set, remove or clear) is taken
// only while the table is idle, and a finished response waits in its own
// register so the next request can be taken while it is unread. The key
// search reads one stored key per cycle from the key RAM's single read port,
// then an optional fetch step, an update step, a reply step and the idle
// state that takes the next request follow; the reply step waits while the
// response register still holds an unread response. A clear skips the
// search. Depends on kvt_pkg, kvt_ctrl, kvt_dp.
module key_value_table_with_valid_marks (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  kvt_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_ready,
  output kvt_pkg::rsp_t out_rsp
);

  kvt_pkg::cmd_t    cmd;
  kvt_pkg::status_t st;

  // Sequence each request
  kvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_req.operation),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Storage, search and response
  kvt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

endmodule
